// ===== design/source_tokenizer_unit_defines.svh =====
// Assertion helpers shared by the checker.
`ifndef SOURCE_TOKENIZER_UNIT_DEFINES_SVH
`define SOURCE_TOKENIZER_UNIT_DEFINES_SVH

// Property that must hold when the enable condition is true.
`define STK_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("check failed");

// Property checked in the cycle after the enable condition.
`define STK_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("check failed");

`endif

// ===== design/stok_pkg.sv =====
`timescale 1ns / 1ps
package stok_pkg;

  localparam int KW_COUNT = 29;
  localparam int KW_BASE  = 25;
  localparam int KW_LEN   = 9;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUM, M_SUFFIX, M_MINUS, M_DQ1, M_DQ2, M_STR,
    M_TRIPLE, M_COMMENT, M_HASH, M_BANG, M_EQ, M_LT1, M_LT2, M_GT
  } mode_t;

  // Token kinds
  localparam logic [5:0] K_END = 6'd0, K_IDENT = 6'd1, K_INT = 6'd2, K_STR = 6'd3,
    K_HASHB = 6'd4, K_MINUS = 6'd16, K_EQEQ = 6'd18, K_EQ = 6'd19, K_NE = 6'd20,
    K_LE = 6'd21, K_LT = 6'd22, K_GE = 6'd23, K_GT = 6'd24;

  // Single character punctuation kinds
  localparam logic [5:0] K_LPAR = 6'd5, K_RPAR = 6'd6, K_LBRACE = 6'd7, K_RBRACE = 6'd8,
    K_LBRACK = 6'd9, K_RBRACK = 6'd10, K_COMMA = 6'd11, K_COLON = 6'd12, K_DOT = 6'd13,
    K_SLASH = 6'd14, K_PLUS = 6'd15, K_STAR = 6'd17;

  // One result word, offsets kept at full width before masking
  typedef struct packed {
    logic [5:0]  kind;
    logic [31:0] s;
    logic [31:0] e;
    logic        bad;
  } tok_t;

  // Keyword text, first character in the low byte, zero padded
  function automatic logic [71:0] kw_text(input int i);
    logic [71:0] t;
    t = '0;
    case (i)
      0:  t = {"ecaps"};
      1:  t = {"llup"};
      2:  t = {"erahs"};
      3:  t = {"mrof"};
      4:  t = {"dleif"};
      5:  t = {"kcip"};
      6:  t = {"esac"};
      7:  t = {"corp"};
      8:  t = {"yrtne"};
      9:  t = {"ta"};
      10: t = {"ekam"};
      11: t = {"tes"};
      12: t = {"evig"};
      13: t = {"time"};
      14: t = {"fi"};
      15: t = {"esiwrehto"};
      16: t = {"tceles"};
      17: t = {"nehw"};
      18: t = {"nruter"};
      19: t = {"ton"};
      20: t = {"dna"};
      21: t = {"ro"};
      22: t = {"sa"};
      23: t = {"lla"};
      24: t = {"eurt"};
      25: t = {"eslaf"};
      26: t = {"loob"};
      27: t = {"gnirts"};
      28: t = {"tni"};
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [3:0] kw_len(input int i);
    logic [3:0] l;
    case (i)
      9, 14, 21, 22: l = 4'd2;
      11, 19, 20, 23, 28: l = 4'd3;
      0, 2, 4, 8, 25: l = 4'd5;
      16, 18, 27: l = 4'd6;
      15: l = 4'd9;
      default: l = 4'd4;
    endcase
    return l;
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
  endfunction
  function automatic logic is_dig(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction
  function automatic logic is_ws(input logic [7:0] b);
    return b == 8'h20 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] b);
    logic [5:0] k;
    case (b)
      "(": k = K_LPAR;   ")": k = K_RPAR;   "{": k = K_LBRACE; "}": k = K_RBRACE;
      "[": k = K_LBRACK; "]": k = K_RBRACK; ",": k = K_COMMA;  ":": k = K_COLON;
      ".": k = K_DOT;    "/": k = K_SLASH;  "+": k = K_PLUS;   "*": k = K_STAR;
      default: k = K_END;
    endcase
    return k;
  endfunction

endpackage

// ===== design/stok_kw_match.sv =====
`timescale 1ns / 1ps
// Parallel keyword compare on the held word
module stok_kw_match (
  input  logic [71:0] word_chars,
  input  logic [3:0]  word_length,
  output logic [5:0]  kind
);
  always_comb begin
    kind = stok_pkg::K_IDENT;
    for (int i = stok_pkg::KW_COUNT - 1; i >= 0; i--) begin
      if (word_length == stok_pkg::kw_len(i) && word_chars == stok_pkg::kw_text(i))
        kind = 6'(stok_pkg::KW_BASE + i);
    end
  end
endmodule

// ===== design/stok_scan.sv =====
`timescale 1ns / 1ps
// Next-state and token logic for one input word
module stok_scan #(
  parameter int OFFSET_BITS = 20
) (
  input  logic [7:0]             b,
  input  logic                   endm,
  input  stok_pkg::mode_t        mode,
  input  logic [OFFSET_BITS-1:0] pos,
  input  logic [OFFSET_BITS-1:0] bg,
  input  logic [71:0]            wchars,
  input  logic [3:0]             wlen,
  input  logic [1:0]             mrun,
  input  logic                   halted,
  output stok_pkg::mode_t        mode_o,
  output logic [OFFSET_BITS-1:0] pos_o,
  output logic [OFFSET_BITS-1:0] bg_o,
  output logic [71:0]            wchars_o,
  output logic [3:0]             wlen_o,
  output logic [1:0]             mrun_o,
  output logic                   halted_o,
  output stok_pkg::tok_t [2:0]   toks,
  output logic [1:0]             ntok
);
  localparam logic [OFFSET_BITS-1:0] OMAX = '1;
  logic [5:0] wkind;
  logic [OFFSET_BITS-1:0] p1, q, q1;

  stok_kw_match u_kw (.word_chars(wchars), .word_length(wlen), .kind(wkind));

  function automatic logic [OFFSET_BITS-1:0] sinc(input logic [OFFSET_BITS-1:0] a);
    return (a == OMAX) ? a : a + 1'b1;
  endfunction
  function automatic logic [31:0] x(input logic [OFFSET_BITS-1:0] a);
    return 32'(a);
  endfunction

  assign p1 = sinc(pos);
  assign q  = sinc(bg);
  assign q1 = sinc(q);

  always_comb begin
    logic st;
    logic [5:0] sk;
    mode_o = mode; pos_o = pos; bg_o = bg; wchars_o = wchars; wlen_o = wlen;
    mrun_o = mrun; halted_o = halted; toks = '0; ntok = 2'd0; st = 1'b0;
    sk = stok_pkg::single_kind(b);
    if (endm) begin
      if (!halted) begin
        if (mode == stok_pkg::M_HASH || mode == stok_pkg::M_BANG) begin
          toks[0] = '{stok_pkg::K_END, x(q), x(q), 1'b1}; ntok = 2'd1;
        end else begin
          case (mode)
            stok_pkg::M_IDENT: begin toks[0] = '{wkind, x(bg), x(pos), 1'b0}; ntok = 2'd1; end
            stok_pkg::M_NUM, stok_pkg::M_SUFFIX: begin
              toks[0] = '{stok_pkg::K_INT, x(bg), x(pos), 1'b0}; ntok = 2'd1; end
            stok_pkg::M_MINUS: begin
              toks[0] = '{stok_pkg::K_MINUS, x(bg), x(q), 1'b0}; ntok = 2'd1; end
            stok_pkg::M_DQ1, stok_pkg::M_DQ2, stok_pkg::M_STR, stok_pkg::M_TRIPLE: begin
              toks[0] = '{stok_pkg::K_STR, x(bg), x(pos), 1'b0}; ntok = 2'd1; end
            stok_pkg::M_EQ: begin toks[0] = '{stok_pkg::K_EQ, x(bg), x(q), 1'b0}; ntok = 2'd1; end
            stok_pkg::M_GT: begin toks[0] = '{stok_pkg::K_GT, x(bg), x(q), 1'b0}; ntok = 2'd1; end
            stok_pkg::M_LT1: begin toks[0] = '{stok_pkg::K_LT, x(bg), x(q), 1'b0}; ntok = 2'd1; end
            stok_pkg::M_LT2: begin
              toks[0] = '{stok_pkg::K_LT, x(bg), x(q), 1'b0};
              toks[1] = '{stok_pkg::K_LT, x(q), x(q1), 1'b0}; ntok = 2'd2; end
            default: ;
          endcase
          toks[ntok] = '{stok_pkg::K_END, x(pos), x(pos), 1'b0};
          ntok = ntok + 2'd1;
        end
      end
      mode_o = stok_pkg::M_IDLE; pos_o = '0; bg_o = '0; wchars_o = '0; wlen_o = '0;
      mrun_o = '0; halted_o = 1'b0;
    end else if (!halted) begin
      pos_o = p1;
      case (mode)
        stok_pkg::M_IDENT:
          if (stok_pkg::is_alpha(b) || stok_pkg::is_dig(b) || b == "_") begin
            if (wlen < 4'(stok_pkg::KW_LEN)) begin
              wchars_o[wlen*8 +: 8] = b; wlen_o = wlen + 4'd1;
            end else wlen_o = 4'(stok_pkg::KW_LEN + 1);
          end else begin
            toks[0] = '{wkind, x(bg), x(pos), 1'b0}; ntok = 2'd1; st = 1'b1;
          end
        stok_pkg::M_NUM:
          if (stok_pkg::is_dig(b)) ;
          else if (stok_pkg::is_alpha(b)) mode_o = stok_pkg::M_SUFFIX;
          else begin toks[0] = '{stok_pkg::K_INT, x(bg), x(pos), 1'b0}; ntok = 2'd1; st = 1'b1; end
        stok_pkg::M_SUFFIX:
          if (!stok_pkg::is_alpha(b)) begin
            toks[0] = '{stok_pkg::K_INT, x(bg), x(pos), 1'b0}; ntok = 2'd1; st = 1'b1;
          end
        stok_pkg::M_MINUS:
          if (stok_pkg::is_dig(b)) mode_o = stok_pkg::M_NUM;
          else begin toks[0] = '{stok_pkg::K_MINUS, x(bg), x(q), 1'b0}; ntok = 2'd1; st = 1'b1; end
        stok_pkg::M_DQ1:
          if (b == "\"") mode_o = stok_pkg::M_DQ2;
          else begin mode_o = stok_pkg::M_STR; mrun_o = (b == "\\") ? 2'd1 : 2'd0; end
        stok_pkg::M_DQ2:
          if (b == "\"") begin mode_o = stok_pkg::M_TRIPLE; mrun_o = '0; end
          else begin toks[0] = '{stok_pkg::K_STR, x(bg), x(pos), 1'b0}; ntok = 2'd1; st = 1'b1; end
        stok_pkg::M_STR:
          if (mrun != 2'd0) mrun_o = '0;
          else if (b == "\"") begin
            toks[0] = '{stok_pkg::K_STR, x(bg), x(p1), 1'b0}; ntok = 2'd1; mode_o = stok_pkg::M_IDLE;
          end else if (b == "\\") mrun_o = 2'd1;
        stok_pkg::M_TRIPLE, stok_pkg::M_COMMENT:
          if (b != ((mode == stok_pkg::M_TRIPLE) ? 8'h22 : 8'h3e)) mrun_o = '0;
          else if (mrun >= 2'd2) begin
            if (mode == stok_pkg::M_TRIPLE) begin
              toks[0] = '{stok_pkg::K_STR, x(bg), x(p1), 1'b0}; ntok = 2'd1;
            end
            mode_o = stok_pkg::M_IDLE; mrun_o = '0;
          end else mrun_o = mrun + 2'd1;
        stok_pkg::M_HASH, stok_pkg::M_BANG:
          if ((mode == stok_pkg::M_HASH && b == "[") || (mode == stok_pkg::M_BANG && b == "=")) begin
            toks[0] = '{(mode == stok_pkg::M_HASH) ? stok_pkg::K_HASHB : stok_pkg::K_NE,
                        x(bg), x(p1), 1'b0};
            ntok = 2'd1; mode_o = stok_pkg::M_IDLE;
          end else begin
            toks[0] = '{stok_pkg::K_END, x(q), x(q), 1'b1}; ntok = 2'd1; halted_o = 1'b1;
          end
        stok_pkg::M_EQ, stok_pkg::M_GT:
          if (b == "=") begin
            toks[0] = '{(mode == stok_pkg::M_EQ) ? stok_pkg::K_EQEQ : stok_pkg::K_GE,
                        x(bg), x(p1), 1'b0};
            ntok = 2'd1; mode_o = stok_pkg::M_IDLE;
          end else begin
            toks[0] = '{(mode == stok_pkg::M_EQ) ? stok_pkg::K_EQ : stok_pkg::K_GT,
                        x(bg), x(q), 1'b0};
            ntok = 2'd1; st = 1'b1;
          end
        stok_pkg::M_LT1:
          if (b == "=") begin
            toks[0] = '{stok_pkg::K_LE, x(bg), x(p1), 1'b0}; ntok = 2'd1; mode_o = stok_pkg::M_IDLE;
          end else if (b == "<") mode_o = stok_pkg::M_LT2;
          else begin toks[0] = '{stok_pkg::K_LT, x(bg), x(q), 1'b0}; ntok = 2'd1; st = 1'b1; end
        stok_pkg::M_LT2:
          if (b == "<") begin mode_o = stok_pkg::M_COMMENT; mrun_o = '0; end
          else begin
            toks[0] = '{stok_pkg::K_LT, x(bg), x(q), 1'b0};
            if (b == "=") begin
              toks[1] = '{stok_pkg::K_LE, x(q), x(p1), 1'b0}; ntok = 2'd2; mode_o = stok_pkg::M_IDLE;
            end else begin
              toks[1] = '{stok_pkg::K_LT, x(q), x(q1), 1'b0}; ntok = 2'd2; st = 1'b1;
            end
          end
        default: st = 1'b1;
      endcase
      // Start a new token on this byte
      if (st) begin
        mode_o = stok_pkg::M_IDLE; bg_o = pos; mrun_o = '0;
        if (stok_pkg::is_alpha(b) || b == "_") begin
          mode_o = stok_pkg::M_IDENT; wchars_o = '0; wchars_o[7:0] = b; wlen_o = 4'd1;
        end else if (stok_pkg::is_dig(b)) mode_o = stok_pkg::M_NUM;
        else if (b == "-") mode_o = stok_pkg::M_MINUS;
        else if (b == "\"") mode_o = stok_pkg::M_DQ1;
        else if (b == "<") mode_o = stok_pkg::M_LT1;
        else if (b == ">") mode_o = stok_pkg::M_GT;
        else if (b == "=") mode_o = stok_pkg::M_EQ;
        else if (b == "!") mode_o = stok_pkg::M_BANG;
        else if (b == "#") mode_o = stok_pkg::M_HASH;
        else if (sk != stok_pkg::K_END) begin
          toks[ntok] = '{sk, x(pos), x(p1), 1'b0}; ntok = ntok + 2'd1;
        end else if (!stok_pkg::is_ws(b)) begin
          toks[ntok] = '{stok_pkg::K_END, x(p1), x(p1), 1'b1}; ntok = ntok + 2'd1;
          halted_o = 1'b1;
        end
      end
    end
  end
endmodule

// ===== design/source_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// A byte's tokens are registered into the result queue when it is taken and appear from the
// cycle after, one token word per cycle while out_stall is low. Input: one byte per cycle when
// it causes at most one token and the output is not stalled; a byte that causes two or three
// tokens holds the input while the result queue drains. State updates once per byte taken.
// Reset (rst_n low, synchronous): scanner returns to between tokens, offsets cleared.
module source_tokenizer_unit #(
  parameter int OFFSET_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte_value,
  input  logic        in_end_marker,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_token_kind,
  output logic [19:0] out_span_start,
  output logic [19:0] out_span_end,
  output logic        out_bad_character,
  output logic        out_last_of_run
);
  stok_pkg::mode_t mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, bg_r, bg_nxt;
  logic [71:0] wc_r, wc_nxt;
  logic [3:0] wl_r, wl_nxt;
  logic [1:0] mr_r, mr_nxt;
  logic halt_r, halt_nxt;
  stok_pkg::tok_t [2:0] toks, q_r;
  logic [1:0] ntok, cnt_r, idx_r;
  logic take, pop;

  stok_scan #(.OFFSET_BITS(OFFSET_BITS)) u_scan (
    .b(in_byte_value), .endm(in_end_marker), .mode(mode_r), .pos(pos_r), .bg(bg_r),
    .wchars(wc_r), .wlen(wl_r), .mrun(mr_r), .halted(halt_r),
    .mode_o(mode_nxt), .pos_o(pos_nxt), .bg_o(bg_nxt), .wchars_o(wc_nxt),
    .wlen_o(wl_nxt), .mrun_o(mr_nxt), .halted_o(halt_nxt), .toks(toks), .ntok(ntok));

  // Result queue holds one byte's tokens; refilled as the last word leaves
  assign out_valid = cnt_r != 2'd0;
  assign pop = out_valid && !out_stall;
  assign in_stall = (cnt_r > 2'd1) || (cnt_r == 2'd1 && out_stall);
  assign take = in_valid && !in_stall;

  assign out_token_kind    = q_r[idx_r].kind;
  assign out_span_start    = q_r[idx_r].s[19:0];
  assign out_span_end      = q_r[idx_r].e[19:0];
  assign out_bad_character = q_r[idx_r].bad;
  assign out_last_of_run   = cnt_r == 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stok_pkg::M_IDLE; pos_r <= '0; bg_r <= '0; wc_r <= '0; wl_r <= '0;
      mr_r <= '0; halt_r <= 1'b0; cnt_r <= '0; idx_r <= '0;
    end else begin
      if (take) begin
        mode_r <= mode_nxt; pos_r <= pos_nxt; bg_r <= bg_nxt; wc_r <= wc_nxt;
        wl_r <= wl_nxt; mr_r <= mr_nxt; halt_r <= halt_nxt;
        q_r <= toks; cnt_r <= ntok; idx_r <= '0;
      end else if (pop) begin
        cnt_r <= cnt_r - 2'd1; idx_r <= idx_r + 2'd1;
      end
    end
  end
endmodule

// ===== design/stok_checker.sv =====
`timescale 1ns / 1ps
`include "source_tokenizer_unit_defines.svh"
// Port-level checks on the tokenizer
module stok_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [5:0] out_token_kind,
  input logic       out_bad_character,
  input logic       out_last_of_run
);
  `STK_ASSERT_IMPL(a_bad_is_end, clk, rst_n, out_valid && out_bad_character, out_token_kind == stok_pkg::K_END)
  `STK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_token_kind))
  `STK_ASSERT_IMPL(a_stall_busy, clk, rst_n, in_stall, out_valid)
  `STK_ASSERT_IMPL(a_end_last, clk, rst_n, out_valid && out_token_kind == stok_pkg::K_END, out_last_of_run)
endmodule

bind source_tokenizer_unit stok_checker u_stok_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_token_kind(out_token_kind),
  .out_bad_character(out_bad_character), .out_last_of_run(out_last_of_run));

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned OFS_MAX = (1 << 20) - 1;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 120;

  typedef struct {
    logic [5:0]  kind;
    logic [19:0] s;
    logic [19:0] e;
    logic        bad;
    logic        last;
  } token_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte_value = '0;
  logic        in_end_marker = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_token_kind;
  logic [19:0] out_span_start;
  logic [19:0] out_span_end;
  logic        out_bad_character;
  logic        out_last_of_run;

  source_tokenizer_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_byte_value(in_byte_value), .in_end_marker(in_end_marker),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_token_kind(out_token_kind), .out_span_start(out_span_start),
    .out_span_end(out_span_end), .out_bad_character(out_bad_character),
    .out_last_of_run(out_last_of_run)
  );

  always #5 clk = ~clk;

  token_word_t tokens_due[$];
  token_word_t step_tokens[$];
  int  errors = 0;
  bit  no_idle = 0;
  int  hold_seq = 0;
  int  hold_seen = 0;
  int  hold_cnt = 0;
  int  quiet_cycles = 0;

  string kw_names[stok_pkg::KW_COUNT] = '{"space", "pull", "share", "form", "field", "pick",
    "case", "proc", "entry", "at", "make", "set", "give", "emit", "if", "otherwise", "select",
    "when", "return", "not", "and", "or", "as", "all", "true", "false", "bool", "string", "int"};

  // Scanner shadow state
  stok_pkg::mode_t scan_st;
  int unsigned     pos_now, tok_begin;
  logic [7:0]      word_buf[stok_pkg::KW_LEN];
  int              word_len, quote_run;
  bit              stopped;

  function automatic int unsigned sat_add(int unsigned a, int unsigned k);
    return (a + k > OFS_MAX) ? OFS_MAX : a + k;
  endfunction

  function automatic bit c_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction
  function automatic bit c_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction
  function automatic bit c_space(logic [7:0] b);
    return b == " " || (b >= 8'd9 && b <= 8'd13);
  endfunction
  function automatic bit c_word(logic [7:0] b);
    return c_alpha(b) || c_digit(b) || b == "_";
  endfunction

  function automatic logic [5:0] punct_kind(logic [7:0] b);
    case (b)
      "(": return stok_pkg::K_LPAR;   ")": return stok_pkg::K_RPAR;
      "{": return stok_pkg::K_LBRACE; "}": return stok_pkg::K_RBRACE;
      "[": return stok_pkg::K_LBRACK; "]": return stok_pkg::K_RBRACK;
      ",": return stok_pkg::K_COMMA;  ":": return stok_pkg::K_COLON;
      ".": return stok_pkg::K_DOT;    "/": return stok_pkg::K_SLASH;
      "+": return stok_pkg::K_PLUS;   "*": return stok_pkg::K_STAR;
      default: return stok_pkg::K_END;
    endcase
  endfunction

  function automatic void add_token(logic [5:0] k, int unsigned s, int unsigned e, bit bad);
    token_word_t t;
    if (step_tokens.size() >= 3) return;
    t.kind = k; t.s = s[19:0]; t.e = e[19:0]; t.bad = bad; t.last = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  function automatic logic [5:0] word_kind();
    bit hit;
    if (word_len > stok_pkg::KW_LEN) return stok_pkg::K_IDENT;
    for (int i = 0; i < stok_pkg::KW_COUNT; i++) begin
      hit = (kw_names[i].len() == word_len);
      for (int j = 0; j < word_len && hit; j++)
        if (kw_names[i][j] != word_buf[j]) hit = 0;
      if (hit) return 6'(stok_pkg::KW_BASE + i);
    end
    return stok_pkg::K_IDENT;
  endfunction

  function automatic void clear_scanner();
    scan_st = stok_pkg::M_IDLE; pos_now = 0; tok_begin = 0; word_len = 0; quote_run = 0;
    stopped = 0;
    foreach (word_buf[i]) word_buf[i] = '0;
  endfunction

  // Start a new token from byte b at offset p
  function automatic void open_token(logic [7:0] b, int unsigned p);
    logic [5:0] k;
    scan_st = stok_pkg::M_IDLE; tok_begin = p; quote_run = 0;
    k = punct_kind(b);
    if (c_alpha(b) || b == "_") begin
      scan_st = stok_pkg::M_IDENT; word_buf[0] = b; word_len = 1;
    end else if (c_digit(b)) scan_st = stok_pkg::M_NUM;
    else if (b == "-") scan_st = stok_pkg::M_MINUS;
    else if (b == "\"") scan_st = stok_pkg::M_DQ1;
    else if (b == "<") scan_st = stok_pkg::M_LT1;
    else if (b == ">") scan_st = stok_pkg::M_GT;
    else if (b == "=") scan_st = stok_pkg::M_EQ;
    else if (b == "!") scan_st = stok_pkg::M_BANG;
    else if (b == "#") scan_st = stok_pkg::M_HASH;
    else if (k != stok_pkg::K_END) add_token(k, p, sat_add(p, 1), 0);
    else if (!c_space(b)) begin
      add_token(stok_pkg::K_END, sat_add(p, 1), sat_add(p, 1), 1);
      stopped = 1;
    end
  endfunction

  // Emit whatever token is pending at end of source
  function automatic void close_pending(int unsigned p);
    int unsigned b1;
    b1 = sat_add(tok_begin, 1);
    case (scan_st)
      stok_pkg::M_IDENT: add_token(word_kind(), tok_begin, p, 0);
      stok_pkg::M_NUM, stok_pkg::M_SUFFIX: add_token(stok_pkg::K_INT, tok_begin, p, 0);
      stok_pkg::M_MINUS: add_token(stok_pkg::K_MINUS, tok_begin, b1, 0);
      stok_pkg::M_DQ1, stok_pkg::M_DQ2, stok_pkg::M_STR, stok_pkg::M_TRIPLE:
        add_token(stok_pkg::K_STR, tok_begin, p, 0);
      stok_pkg::M_EQ: add_token(stok_pkg::K_EQ, tok_begin, b1, 0);
      stok_pkg::M_GT: add_token(stok_pkg::K_GT, tok_begin, b1, 0);
      stok_pkg::M_LT1: add_token(stok_pkg::K_LT, tok_begin, b1, 0);
      stok_pkg::M_LT2: begin
        add_token(stok_pkg::K_LT, tok_begin, b1, 0);
        add_token(stok_pkg::K_LT, b1, sat_add(b1, 1), 0);
      end
      default: ;
    endcase
  endfunction

  // Work out the token words caused by one accepted input word
  function automatic void predict_tokens(logic [7:0] b, bit endm);
    int unsigned p, bg, q;
    token_word_t t;
    step_tokens.delete();
    bg = tok_begin; q = sat_add(tok_begin, 1);
    if (endm) begin
      if (!stopped) begin
        if (scan_st == stok_pkg::M_HASH || scan_st == stok_pkg::M_BANG)
          add_token(stok_pkg::K_END, q, q, 1);
        else begin
          close_pending(pos_now);
          add_token(stok_pkg::K_END, pos_now, pos_now, 0);
        end
      end
      clear_scanner();
    end else if (!stopped) begin
      p = pos_now;
      pos_now = sat_add(p, 1);
      case (scan_st)
        stok_pkg::M_IDENT:
          if (c_word(b)) begin
            if (word_len < stok_pkg::KW_LEN) begin word_buf[word_len] = b; word_len++; end
            else word_len = stok_pkg::KW_LEN + 1;
          end else begin
            add_token(word_kind(), bg, p, 0); open_token(b, p);
          end
        stok_pkg::M_NUM:
          if (c_alpha(b)) scan_st = stok_pkg::M_SUFFIX;
          else if (!c_digit(b)) begin add_token(stok_pkg::K_INT, bg, p, 0); open_token(b, p); end
        stok_pkg::M_SUFFIX:
          if (!c_alpha(b)) begin add_token(stok_pkg::K_INT, bg, p, 0); open_token(b, p); end
        stok_pkg::M_MINUS:
          if (c_digit(b)) scan_st = stok_pkg::M_NUM;
          else begin add_token(stok_pkg::K_MINUS, bg, q, 0); open_token(b, p); end
        stok_pkg::M_DQ1:
          if (b == "\"") scan_st = stok_pkg::M_DQ2;
          else begin scan_st = stok_pkg::M_STR; quote_run = (b == "\\") ? 1 : 0; end
        stok_pkg::M_DQ2:
          if (b == "\"") begin scan_st = stok_pkg::M_TRIPLE; quote_run = 0; end
          else begin add_token(stok_pkg::K_STR, bg, p, 0); open_token(b, p); end
        stok_pkg::M_STR:
          if (quote_run != 0) quote_run = 0;
          else if (b == "\"") begin
            add_token(stok_pkg::K_STR, bg, pos_now, 0); scan_st = stok_pkg::M_IDLE;
          end else if (b == "\\") quote_run = 1;
        stok_pkg::M_TRIPLE:
          if (b != "\"") quote_run = 0;
          else begin
            quote_run++;
            if (quote_run >= 3) begin
              add_token(stok_pkg::K_STR, bg, pos_now, 0); scan_st = stok_pkg::M_IDLE;
              quote_run = 0;
            end
          end
        stok_pkg::M_COMMENT:
          if (b != ">") quote_run = 0;
          else begin
            quote_run++;
            if (quote_run >= 3) begin scan_st = stok_pkg::M_IDLE; quote_run = 0; end
          end
        stok_pkg::M_HASH, stok_pkg::M_BANG:
          if ((scan_st == stok_pkg::M_HASH && b == "[") ||
              (scan_st == stok_pkg::M_BANG && b == "=")) begin
            add_token(scan_st == stok_pkg::M_HASH ? stok_pkg::K_HASHB : stok_pkg::K_NE,
                      bg, pos_now, 0);
            scan_st = stok_pkg::M_IDLE;
          end else begin
            add_token(stok_pkg::K_END, q, q, 1); stopped = 1;
          end
        stok_pkg::M_EQ:
          if (b == "=") begin
            add_token(stok_pkg::K_EQEQ, bg, pos_now, 0); scan_st = stok_pkg::M_IDLE;
          end else begin add_token(stok_pkg::K_EQ, bg, q, 0); open_token(b, p); end
        stok_pkg::M_GT:
          if (b == "=") begin
            add_token(stok_pkg::K_GE, bg, pos_now, 0); scan_st = stok_pkg::M_IDLE;
          end else begin add_token(stok_pkg::K_GT, bg, q, 0); open_token(b, p); end
        stok_pkg::M_LT1:
          if (b == "=") begin
            add_token(stok_pkg::K_LE, bg, pos_now, 0); scan_st = stok_pkg::M_IDLE;
          end else if (b == "<") scan_st = stok_pkg::M_LT2;
          else begin add_token(stok_pkg::K_LT, bg, q, 0); open_token(b, p); end
        stok_pkg::M_LT2:
          if (b == "<") begin scan_st = stok_pkg::M_COMMENT; quote_run = 0; end
          else begin
            add_token(stok_pkg::K_LT, bg, q, 0);
            if (b == "=") begin
              add_token(stok_pkg::K_LE, q, pos_now, 0); scan_st = stok_pkg::M_IDLE;
            end else begin
              add_token(stok_pkg::K_LT, q, sat_add(q, 1), 0); open_token(b, p);
            end
          end
        default: open_token(b, p);
      endcase
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) begin
      t = step_tokens[i];
      tokens_due.insert(tokens_due.size(), t);
    end
  endfunction

  // Send one input word, waiting out a random gap first
  task automatic send_word(logic [7:0] b, bit endm);
    int gap;
    gap = (!no_idle && $urandom_range(99) < 33) ? 1 : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_value <= endm ? 8'($urandom) : b;
    in_end_marker <= endm;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(b, endm);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 0);
  endtask

  task automatic send_end();
    send_word(8'h00, 1);
  endtask

  // Random well-formed token text
  task automatic send_random_token();
    string s;
    int n;
    s = "";
    case ($urandom_range(9))
      0, 1: s = kw_names[$urandom_range(stok_pkg::KW_COUNT - 1)];
      2: begin
        n = $urandom_range(12, 1);
        s = "_";
        for (int i = 0; i < n; i++) s = $sformatf("%s%c", s, 8'("a" + $urandom_range(25)));
      end
      3: begin
        if ($urandom_range(1)) s = "-";
        n = $urandom_range(5, 1);
        for (int i = 0; i < n; i++) s = $sformatf("%s%c", s, 8'("0" + $urandom_range(9)));
        if ($urandom_range(2) == 0) s = {s, "uL"};
      end
      4: s = $urandom_range(1) ? "\"ab\\\"c\\\\\"" : "\"\"";
      5: s = "\"\"\"q\"r\"\"x\"\"\"";
      6: s = "<<< c > >> ok >>>";
      7: begin
        case ($urandom_range(11))
          0: s = "#["; 1: s = "!="; 2: s = "=="; 3: s = "<="; 4: s = ">=";
          5: s = "<<="; 6: s = "<<"; 7: s = "<"; 8: s = ">"; 9: s = "=";
          10: s = "-"; default: s = $sformatf("%c", 8'("(" + $urandom_range(3)));
        endcase
      end
      8: s = $urandom_range(1) ? "{}[],:./+*" : "\t\n\r ";
      default: s = " ";
    endcase
    send_text(s);
    if ($urandom_range(1)) send_word(" ", 0);
  endtask

  task automatic test_directed();
    send_text("otherwise xy9_");
    send_end();
    send_text("-7kg \"a\\\"b\" <<<z>>><<=");
    send_end();
    send_word(8'hff, 0);
    send_word("a", 0);
    send_end();
    send_text("#x");
    send_end();
    send_text("!");
    send_end();
    send_text("abcdefghijkl\"\"\"u");
    send_end();
  endtask

  task automatic test_random();
    for (int i = 0; i < 48; i++) begin
      no_idle = (i >= 16 && i < 32);
      if ($urandom_range(29) == 0) send_word(8'($urandom), 0);
      else send_random_token();
      if ($urandom_range(19) == 0) send_end();
    end
    no_idle = 0;
    send_end();
  endtask

  task automatic test_backpressure();
    hold_seq++;
    for (int i = 0; i < 20; i++) send_text("<< ");
    send_end();
  endtask

  // Result side stall
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_cnt = HOLD_CYCLES;
      hold_seen = hold_seq;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (!no_idle && $urandom_range(99) < 25);
    end
  end

  // Token word checker
  always @(posedge clk) begin
    token_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        $error("token word with none due: kind %0d", out_token_kind);
        errors++;
      end else begin
        w = tokens_due.pop_front();
        if (out_token_kind !== w.kind) begin
          $error("token_kind exp %0d got %0d", w.kind, out_token_kind); errors++;
        end
        if (out_span_start !== w.s) begin
          $error("span_start exp %0d got %0d", w.s, out_span_start); errors++;
        end
        if (out_span_end !== w.e) begin
          $error("span_end exp %0d got %0d", w.e, out_span_end); errors++;
        end
        if (out_bad_character !== w.bad) begin
          $error("bad_character exp %0d got %0d", w.bad, out_bad_character); errors++;
        end
        if (out_last_of_run !== w.last) begin
          $error("last_of_run exp %0d got %0d", w.last, out_last_of_run); errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    clear_scanner();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    in_valid <= 1'b0;
    while (tokens_due.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
